// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the line clip / viewport core.
// Included by modules that carry concurrent checks; expects a clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk, muted while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on clk, also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hlcv_pkg.sv =====
// Shared types, constants and helper functions for the line clip / viewport core.
// No dependencies; used by hlcv_div and homogeneous_line_clip_viewport_unit.
`timescale 1ns / 1ps

package hlcv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = 32;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 34;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int CLIP_LAT  = DIV_LAT + 6;
  localparam int PIPE_DEPTH = 2 * CLIP_LAT + DIV_LAT + 4;
  localparam int DEP_W     = 25;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX = 2'd3;

  localparam logic [13:0] VP_WIDTH_RST  = 14'd640;
  localparam logic [13:0] VP_HEIGHT_RST = 14'd480;
  localparam logic [16:0] DEPTH_MIN_RST = 17'd0;
  localparam logic [16:0] DEPTH_MAX_RST = 17'd65536;

  localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

  // crossing factor kind per axis
  typedef enum logic [1:0] {
    XC_NONE,
    XC_MAX,
    XC_DIV
  } xcls_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic        [31:0] a_color;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic        [31:0] b_color;
  } line_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] sa_x;
    logic signed [31:0] sa_y;
    logic signed [31:0] sa_z;
    logic        [31:0] sa_color;
    logic signed [31:0] sb_x;
    logic signed [31:0] sb_y;
    logic signed [31:0] sb_z;
    logic        [31:0] sb_color;
  } line_out_t;

  // p[0..3] = x, y, z, w
  typedef struct packed {
    logic [3:0][31:0] p;
    logic [31:0]      col;
  } vtx_t;

  // v is clipped toward o
  typedef struct packed {
    vtx_t v;
    vtx_t o;
  } vpair_t;

  typedef struct packed {
    vpair_t           pr;
    logic [3:0][32:0] dir;
    xcls_t [2:0]      cls;
  } clip_sb_t;

  typedef struct packed {
    logic             rej;
    logic [5:0]       neg;
    logic [1:0][31:0] col;
  } map_sb_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q1.16 depth register to FRAC_BITS fraction bits, floor
  function automatic logic [DEP_W-1:0] depth_fx(input logic [16:0] d);
    logic [DEP_W-1:0] r;
    if (FRAC_BITS >= 16) begin
      r = DEP_W'(d) << (FRAC_BITS - 16);
    end else begin
      r = DEP_W'(d) >> (16 - FRAC_BITS);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hlcv_div.sv =====
// Pipelined unsigned fixed-point divider: (num << FRAC_BITS) / den, one quotient bit per stage.
// Depends on hlcv_pkg for widths; every stage advances only on en.
`timescale 1ns / 1ps

module hlcv_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hlcv_pkg::NUM_W-1:0]   num,
  input  logic [hlcv_pkg::DEN_W-1:0]   den,
  output logic [hlcv_pkg::QUO_W-1:0]   quo,
  output logic                         ovf
);

  localparam int X_W   = hlcv_pkg::NUM_W + hlcv_pkg::FRAC_BITS;
  localparam int CMP_W = hlcv_pkg::DEN_W + hlcv_pkg::QUO_W;
  localparam int QW    = hlcv_pkg::QUO_W;
  localparam int DW    = hlcv_pkg::DEN_W;

  logic [X_W-1:0] x;
  logic           ovf_in;

  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] lo  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic          of  [QW+1];

  assign x = X_W'(num) << hlcv_pkg::FRAC_BITS;
  // quotient would not fit in QW bits
  assign ovf_in = CMP_W'(x) >= (CMP_W'(den) << QW);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(x >> QW);
      lo[0]  <= x[QW-1:0];
      q[0]   <= '0;
      dv[0]  <= den;
      of[0]  <= ovf_in;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW+1:0] diff;
    logic          ge;

    assign diff = {1'b0, rem[j], lo[j][QW-1]} - {2'b00, dv[j]};
    assign ge   = ~diff[DW+1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? diff[DW-1:0] : {rem[j][DW-2:0], lo[j][QW-1]};
        lo[j+1]  <= {lo[j][QW-2:0], 1'b0};
        q[j+1]   <= {q[j][QW-2:0], ge};
        dv[j+1]  <= dv[j];
        of[j+1]  <= of[j];
      end
    end
  end

  assign quo = q[QW];
  assign ovf = of[QW];

endmodule

// ===== rtl/core/homogeneous_line_clip_viewport_unit.sv =====
// Homogeneous line clip and viewport unit: clips A toward B, then B toward clipped A,
// then divides by w and maps to the viewport and depth range.
// Pipe: two clip passes of 39 stages each, then 37 mapping stages; each pass
// is dominated by a 33-stage bit-per-stage divider.
// Throughput: one line per cycle; the whole pipe stalls only when the output beat is held.
// Reset (rst, synchronous): clears all stage valid bits and restores the viewport registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module homogeneous_line_clip_viewport_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hlcv_pkg::line_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hlcv_pkg::line_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [hlcv_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hlcv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int F   = hlcv_pkg::FRAC_BITS;
  localparam int DL  = hlcv_pkg::DIV_LAT;
  localparam int PD  = hlcv_pkg::PIPE_DEPTH;
  localparam int DPW = hlcv_pkg::DEP_W;

  // ---------------------------------------------------------------------------
  // Configuration registers (the user must write them only while the pipe is empty; not enforced here)
  // ---------------------------------------------------------------------------
  logic [13:0] vp_width;
  logic [13:0] vp_height;
  logic [16:0] depth_min;
  logic [16:0] depth_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= hlcv_pkg::VP_WIDTH_RST;
      vp_height <= hlcv_pkg::VP_HEIGHT_RST;
      depth_min <= hlcv_pkg::DEPTH_MIN_RST;
      depth_max <= hlcv_pkg::DEPTH_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hlcv_pkg::REG_VP_WIDTH:  vp_width  <= cfg_data[13:0];
        hlcv_pkg::REG_VP_HEIGHT: vp_height <= cfg_data[13:0];
        hlcv_pkg::REG_DEPTH_MIN: depth_min <= cfg_data;
        hlcv_pkg::REG_DEPTH_MAX: depth_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control: every stage moves together; the valid chain rides along.
  // Output register is the last stage, so a held output beat stalls the pipe
  // but a free output slot lets a new line enter every cycle.
  // ---------------------------------------------------------------------------
  logic [PD-1:0] vld;
  logic          adv;

  assign adv       = ~vld[PD-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PD-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Two clip passes. Pass 0 clips A toward B; pass 1 clips B toward clipped A.
  // Stages per pass: c0 capture, c1 direction, c2 crossing setup, divider,
  // c3 t select, c4 products, c5 apply and saturate.
  // ---------------------------------------------------------------------------
  hlcv_pkg::vpair_t pass_in  [2];
  hlcv_pkg::vpair_t pass_out [2];

  assign pass_in[0].v.p   = {in_data.a_w, in_data.a_z, in_data.a_y, in_data.a_x};
  assign pass_in[0].v.col = in_data.a_color;
  assign pass_in[0].o.p   = {in_data.b_w, in_data.b_z, in_data.b_y, in_data.b_x};
  assign pass_in[0].o.col = in_data.b_color;
  assign pass_in[1].v     = pass_out[0].o;
  assign pass_in[1].o     = pass_out[0].v;

  for (genvar k = 0; k < 2; k++) begin : g_pass
    hlcv_pkg::vpair_t c0_pr;
    hlcv_pkg::vpair_t c1_pr;
    logic [3:0][32:0] c1_dir_next;
    logic [3:0][32:0] c1_dir;
    hlcv_pkg::clip_sb_t c2_sb_next;
    hlcv_pkg::clip_sb_t c2_sb;
    logic [2:0][hlcv_pkg::NUM_W-1:0] c2_num_next;
    logic [2:0][hlcv_pkg::NUM_W-1:0] c2_num;
    logic [2:0][hlcv_pkg::DEN_W-1:0] c2_den_next;
    logic [2:0][hlcv_pkg::DEN_W-1:0] c2_den;
    hlcv_pkg::clip_sb_t sb_d [DL];
    logic [2:0][31:0] quo;
    logic [2:0]       ovf;
    logic [2:0][30:0] t_ax;
    logic [30:0]      c3_t_next;
    logic [30:0]      c3_t;
    hlcv_pkg::vpair_t c3_pr;
    logic [3:0][32:0] c3_dir;
    logic [3:0][64:0] c4_prod_next;
    logic [3:0][64:0] c4_prod;
    logic [3:0][40:0] c4_cprod_next;
    logic [3:0][40:0] c4_cprod;
    hlcv_pkg::vpair_t c4_pr;
    hlcv_pkg::vpair_t c5_next;

    // c0
    always_ff @(posedge clk) begin
      if (adv) begin
        c0_pr <= pass_in[k];
      end
    end

    // c1: d = O - V
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        c1_dir_next[i] = 33'($signed(c0_pr.o.p[i])) - 33'($signed(c0_pr.v.p[i]));
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c1_pr  <= c0_pr;
        c1_dir <= c1_dir_next;
      end
    end

    // c2: plane tests, numerator and denominator per axis
    always_comb begin
      c2_sb_next.pr  = c1_pr;
      c2_sb_next.dir = c1_dir;
      for (int i = 0; i < 3; i++) begin : b_ax
        logic signed [33:0] c;
        logic signed [33:0] w;
        logic signed [33:0] nm;
        logic signed [34:0] dc;
        logic signed [34:0] dw;
        logic signed [34:0] dn;
        logic               gt;
        logic               lt;
        c  = 34'($signed(c1_pr.v.p[i]));
        w  = 34'($signed(c1_pr.v.p[3]));
        dc = 35'($signed(c1_dir[i]));
        dw = 35'($signed(c1_dir[3]));
        gt = c > w;
        lt = c < -w;
        nm = gt ? (c - w) : -(c + w);
        dn = gt ? (dw - dc) : (dw + dc);
        c2_num_next[i] = nm[hlcv_pkg::NUM_W-1:0];
        if ((!gt && !lt) || dn < 0) begin
          c2_sb_next.cls[i] = hlcv_pkg::XC_NONE;
          c2_den_next[i]    = hlcv_pkg::DEN_W'(1);
        end else if (dn == 0) begin
          c2_sb_next.cls[i] = hlcv_pkg::XC_MAX;
          c2_den_next[i]    = hlcv_pkg::DEN_W'(1);
        end else begin
          c2_sb_next.cls[i] = hlcv_pkg::XC_DIV;
          c2_den_next[i]    = dn[hlcv_pkg::DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c2_sb  <= c2_sb_next;
        c2_num <= c2_num_next;
        c2_den <= c2_den_next;
      end
    end

    // crossing dividers, sideband delayed alongside
    for (genvar i = 0; i < 3; i++) begin : g_div
      hlcv_div u_div (
        .clk (clk),
        .en  (adv),
        .num (c2_num[i]),
        .den (c2_den[i]),
        .quo (quo[i]),
        .ovf (ovf[i])
      );
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sb_d[0] <= c2_sb;
        for (int s = 1; s < DL; s++) begin
          sb_d[s] <= sb_d[s-1];
        end
      end
    end

    // c3: t = max(0, t_x, t_y, t_z), saturated
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        case (sb_d[DL-1].cls[i])
          hlcv_pkg::XC_DIV:
            t_ax[i] = (ovf[i] || quo[i][31]) ? hlcv_pkg::T_MAX : quo[i][30:0];
          hlcv_pkg::XC_MAX: t_ax[i] = hlcv_pkg::T_MAX;
          default:          t_ax[i] = '0;
        endcase
      end
      c3_t_next = (t_ax[0] > t_ax[1]) ? t_ax[0] : t_ax[1];
      if (t_ax[2] > c3_t_next) begin
        c3_t_next = t_ax[2];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c3_t   <= c3_t_next;
        c3_pr  <= sb_d[DL-1].pr;
        c3_dir <= sb_d[DL-1].dir;
      end
    end

    // c4: t * d and t * (O - V) per color channel
    always_comb begin
      for (int i = 0; i < 4; i++) begin : b_mul
        logic signed [31:0] ts;
        logic signed [32:0] ds;
        logic signed [8:0]  dch;
        ts = $signed({1'b0, c3_t});
        ds = $signed(c3_dir[i]);
        dch = $signed({1'b0, c3_pr.o.col[8*i +: 8]}) - $signed({1'b0, c3_pr.v.col[8*i +: 8]});
        c4_prod_next[i]  = ts * ds;
        c4_cprod_next[i] = dch * ts;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c4_prod  <= c4_prod_next;
        c4_cprod <= c4_cprod_next;
        c4_pr    <= c3_pr;
      end
    end

    // c5: V += floor(t*d), color rounds half up and clamps
    always_comb begin
      c5_next.o = c4_pr.o;
      for (int i = 0; i < 4; i++) begin : b_app
        logic signed [31:0] vi;
        logic signed [64:0] psh;
        logic signed [40:0] cp;
        logic signed [41:0] cs;
        logic signed [41:0] n;
        vi  = $signed(c4_pr.v.p[i]);
        psh = $signed(c4_prod[i]) >>> F;
        c5_next.v.p[i] = hlcv_pkg::sat32(66'(vi) + 66'(psh));
        cp = $signed(c4_cprod[i]);
        cs = (42'(cp) + 42'(1 << (F - 1))) >>> F;
        n  = 42'($signed({1'b0, c4_pr.v.col[8*i +: 8]})) + cs;
        if (n < 0) begin
          c5_next.v.col[8*i +: 8] = 8'd0;
        end else if (n > 42'sd255) begin
          c5_next.v.col[8*i +: 8] = 8'd255;
        end else begin
          c5_next.v.col[8*i +: 8] = n[7:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pass_out[k] <= c5_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mapping: m0 magnitudes and reject test, divider, m2 signed NDC,
  // m3 viewport / depth products, m4 final saturation into the output beat.
  // Index j*3+i: vertex j (0 = A, 1 = B), component i (x, y, z).
  // ---------------------------------------------------------------------------
  hlcv_pkg::vtx_t mv [2];
  logic [5:0][hlcv_pkg::NUM_W-1:0] m0_num_next;
  logic [5:0][hlcv_pkg::NUM_W-1:0] m0_num;
  logic [5:0][hlcv_pkg::DEN_W-1:0] m0_den_next;
  logic [5:0][hlcv_pkg::DEN_W-1:0] m0_den;
  hlcv_pkg::map_sb_t m0_sb_next;
  hlcv_pkg::map_sb_t m0_sb;
  hlcv_pkg::map_sb_t m_sb_d [DL];
  logic [5:0][31:0] m_quo;
  logic [5:0]       m_ovf;
  logic [5:0][31:0] m2_n_next;
  logic [5:0][31:0] m2_n;
  hlcv_pkg::map_sb_t m2_sb;
  logic [1:0][47:0] m3_px_next;
  logic [1:0][47:0] m3_px;
  logic [1:0][47:0] m3_py_next;
  logic [1:0][47:0] m3_py;
  logic [1:0][DPW+32:0] m3_pz_next;
  logic [1:0][DPW+32:0] m3_pz;
  logic [DPW:0]     m3_bias_next;
  logic [DPW-1:0]   m3_bias;
  hlcv_pkg::map_sb_t m3_sb;
  hlcv_pkg::line_out_t out_next;

  assign mv[0] = pass_out[1].o;
  assign mv[1] = pass_out[1].v;

  always_comb begin
    m0_sb_next.rej = (mv[0].p[3] == '0) || (mv[1].p[3] == '0);
    m0_sb_next.col = {mv[1].col, mv[0].col};
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 3; i++) begin : b_abs
        logic signed [32:0] c;
        logic signed [33:0] w;
        c = 33'($signed(mv[j].p[i]));
        w = 34'($signed(mv[j].p[3]));
        m0_num_next[j*3+i] = (c < 0) ? -c : c;
        if (w == 0) begin
          m0_den_next[j*3+i] = hlcv_pkg::DEN_W'(1);
        end else begin
          m0_den_next[j*3+i] = (w < 0) ? -w : w;
        end
        m0_sb_next.neg[j*3+i] = mv[j].p[i][31] ^ mv[j].p[3][31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_num <= m0_num_next;
      m0_den <= m0_den_next;
      m0_sb  <= m0_sb_next;
    end
  end

  for (genvar d = 0; d < 6; d++) begin : g_mdiv
    hlcv_div u_div (
      .clk (clk),
      .en  (adv),
      .num (m0_num[d]),
      .den (m0_den[d]),
      .quo (m_quo[d]),
      .ovf (m_ovf[d])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sb_d[0] <= m0_sb;
      for (int s = 1; s < DL; s++) begin
        m_sb_d[s] <= m_sb_d[s-1];
      end
    end
  end

  // m2: apply sign, saturate to 32 bits
  always_comb begin
    for (int d = 0; d < 6; d++) begin : b_ndc
      logic signed [33:0] mag;
      logic signed [33:0] sv;
      mag = m_ovf[d] ? 34'sh1_0000_0000 : $signed({2'b00, m_quo[d]});
      sv  = m_sb_d[DL-1].neg[d] ? -mag : mag;
      m2_n_next[d] = hlcv_pkg::sat32(66'(sv));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_n  <= m2_n_next;
      m2_sb <= m_sb_d[DL-1];
    end
  end

  // m3: (n + 1) * size, (dmax - dmin) * nz
  always_comb begin
    logic [DPW-1:0]     dmx;
    logic [DPW-1:0]     dmn;
    logic signed [DPW:0] dd;
    logic signed [14:0] wv;
    logic signed [14:0] hv;
    dmx = hlcv_pkg::depth_fx(depth_max);
    dmn = hlcv_pkg::depth_fx(depth_min);
    dd  = $signed({1'b0, dmx}) - $signed({1'b0, dmn});
    wv  = $signed({1'b0, vp_width});
    hv  = $signed({1'b0, vp_height});
    m3_bias_next = ({1'b0, dmx} + {1'b0, dmn}) >> 1;
    for (int j = 0; j < 2; j++) begin : b_vp
      logic signed [32:0] nx1;
      logic signed [32:0] ny1;
      logic signed [31:0] nz;
      nx1 = 33'($signed(m2_n[j*3])) + 33'(1 << F);
      ny1 = 33'($signed(m2_n[j*3+1])) + 33'(1 << F);
      nz  = $signed(m2_n[j*3+2]);
      m3_px_next[j] = nx1 * wv;
      m3_py_next[j] = ny1 * hv;
      m3_pz_next[j] = dd * nz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_px   <= m3_px_next;
      m3_py   <= m3_py_next;
      m3_pz   <= m3_pz_next;
      m3_bias <= m3_bias_next[DPW-1:0];
      m3_sb   <= m2_sb;
    end
  end

  // m4: halve, add depth bias, saturate; a rejected line leaves all zero
  always_comb begin
    logic [1:0][31:0] sx;
    logic [1:0][31:0] sy;
    logic [1:0][31:0] sz;
    for (int j = 0; j < 2; j++) begin : b_fin
      logic signed [47:0]    hx;
      logic signed [47:0]    hy;
      logic signed [DPW+32:0] hz;
      hx = $signed(m3_px[j]) >>> 1;
      hy = $signed(m3_py[j]) >>> 1;
      hz = $signed(m3_pz[j]) >>> (F + 1);
      sx[j] = hlcv_pkg::sat32(66'(hx));
      sy[j] = hlcv_pkg::sat32(66'(hy));
      sz[j] = hlcv_pkg::sat32(66'(hz) + 66'({1'b0, m3_bias}));
    end
    if (m3_sb.rej) begin
      out_next = '0;
    end else begin
      out_next.accepted = 1'b1;
      out_next.sa_x     = sx[0];
      out_next.sa_y     = sy[0];
      out_next.sa_z     = sz[0];
      out_next.sa_color = m3_sb.col[0];
      out_next.sb_x     = sx[1];
      out_next.sb_y     = sy[1];
      out_next.sb_z     = sz[1];
      out_next.sb_color = m3_sb.col[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(a_rej_zero, out_valid && !out_data.accepted |-> (out_data.sa_x == '0) && (out_data.sb_z == '0) && (out_data.sb_color == '0), "rejected line beat carries nonzero payload")
  `ASSERT_CLK(a_stall_hold, !in_ready |=> $stable(vld), "pipe valid chain moved during a stall")
  `ASSERT_CLK(a_accept_enters, in_valid && in_ready |=> vld[0], "accepted line did not enter the first stage")
  `ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid, "output valid right after reset")

endmodule

// ===== tb/sv/hlcv_line_checker.sv =====
// Scoreboard for the line clip / viewport unit: mirrors the viewport registers,
// predicts each line result and compares every output beat. Depends on hlcv_pkg.
`timescale 1ns / 1ps

module hlcv_line_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  hlcv_pkg::line_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  hlcv_pkg::line_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [hlcv_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hlcv_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);
  import hlcv_pkg::*;

  localparam longint ONE  = 64'sd1 <<< FRAC_BITS;
  localparam longint TTOP = 64'sd2147483647;

  typedef struct {
    longint      p[4];
    logic [31:0] col;
  } vert_t;

  longint vp_w, vp_h, dep_lo, dep_hi;
  line_out_t lines_due[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint plane_t(longint c, longint w, longint dc, longint dw);
    longint num, den, q;
    if (c > w) begin
      num = c - w;
      den = dw - dc;
    end else if (c < -w) begin
      num = -(c + w);
      den = dw + dc;
    end else begin
      return 0;
    end
    if (den < 0) return 0;
    if (den == 0) return TTOP;
    q = (num * ONE) / den;
    return (q > TTOP) ? TTOP : q;
  endfunction

  function automatic vert_t pull_toward(vert_t v, vert_t o);
    longint d[4];
    longint t, c, ca, cb, n;
    vert_t r;
    t = 0;
    for (int i = 0; i < 4; i++) d[i] = o.p[i] - v.p[i];
    for (int i = 0; i < 3; i++) begin
      c = plane_t(v.p[i], v.p[3], d[i], d[3]);
      if (c > t) t = c;
    end
    for (int i = 0; i < 4; i++) r.p[i] = clamp32(v.p[i] + ((t * d[i]) >>> FRAC_BITS));
    r.col = '0;
    for (int i = 0; i < 4; i++) begin
      ca = longint'(v.col[8*i +: 8]);
      cb = longint'(o.col[8*i +: 8]);
      n = ca + (((cb - ca) * t + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (n < 0) n = 0;
      if (n > 255) n = 255;
      r.col[8*i +: 8] = n[7:0];
    end
    return r;
  endfunction

  function automatic logic [127:0] to_screen(vert_t v);
    longint nx, ny, nz, lo, hi, sx, sy, sz;
    nx = clamp32((v.p[0] * ONE) / v.p[3]);
    ny = clamp32((v.p[1] * ONE) / v.p[3]);
    nz = clamp32((v.p[2] * ONE) / v.p[3]);
    lo = (FRAC_BITS >= 16) ? (dep_lo <<< (FRAC_BITS - 16)) : (dep_lo >>> (16 - FRAC_BITS));
    hi = (FRAC_BITS >= 16) ? (dep_hi <<< (FRAC_BITS - 16)) : (dep_hi >>> (16 - FRAC_BITS));
    sx = clamp32(((nx + ONE) * vp_w) >>> 1);
    sy = clamp32(((ny + ONE) * vp_h) >>> 1);
    sz = clamp32((((hi - lo) * nz) >>> (FRAC_BITS + 1)) + ((hi + lo) >>> 1));
    return {sx[31:0], sy[31:0], sz[31:0], v.col};
  endfunction

  function automatic line_out_t predict_line(line_in_t li);
    vert_t a, b;
    line_out_t r;
    a.p[0] = li.a_x; a.p[1] = li.a_y; a.p[2] = li.a_z; a.p[3] = li.a_w; a.col = li.a_color;
    b.p[0] = li.b_x; b.p[1] = li.b_y; b.p[2] = li.b_z; b.p[3] = li.b_w; b.col = li.b_color;
    a = pull_toward(a, b);
    b = pull_toward(b, a);
    r = '0;
    if (a.p[3] != 0 && b.p[3] != 0) begin
      r.accepted = 1'b1;
      {r.sa_x, r.sa_y, r.sa_z, r.sa_color} = to_screen(a);
      {r.sb_x, r.sb_y, r.sb_z, r.sb_color} = to_screen(b);
    end
    return r;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  assign pending = lines_due.size();

  always @(posedge clk) begin
    line_out_t e;
    if (rst) begin
      vp_w   = VP_WIDTH_RST;
      vp_h   = VP_HEIGHT_RST;
      dep_lo = DEPTH_MIN_RST;
      dep_hi = DEPTH_MAX_RST;
      lines_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_VP_WIDTH:  vp_w   = cfg_data[13:0];
          REG_VP_HEIGHT: vp_h   = cfg_data[13:0];
          REG_DEPTH_MIN: dep_lo = cfg_data[16:0];
          REG_DEPTH_MAX: dep_hi = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) lines_due.push_back(predict_line(in_data));
      if (out_valid && out_ready) begin
        if (lines_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output beat %h", out_data);
        end else begin
          e = lines_due.pop_front();
          cmp_field("accepted", 32'(e.accepted), 32'(out_data.accepted));
          cmp_field("sa_x", e.sa_x, out_data.sa_x);
          cmp_field("sa_y", e.sa_y, out_data.sa_y);
          cmp_field("sa_z", e.sa_z, out_data.sa_z);
          cmp_field("sa_color", e.sa_color, out_data.sa_color);
          cmp_field("sb_x", e.sb_x, out_data.sb_x);
          cmp_field("sb_y", e.sb_y, out_data.sb_y);
          cmp_field("sb_z", e.sb_z, out_data.sb_z);
          cmp_field("sb_color", e.sb_color, out_data.sb_color);
        end
      end
    end
  end

endmodule

// ===== tb/sv/homogeneous_line_clip_viewport_unit_tb.sv =====
// Top of the line clip / viewport testbench: clock, reset, line stimulus, register
// phases and verdict. Depends on hlcv_pkg, hlcv_line_checker and the unit itself.
`timescale 1ns / 1ps

module homogeneous_line_clip_viewport_unit_tb;
  import hlcv_pkg::*;

  localparam int Q = 65536;          // 1.0 in Q16.16
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = 160;   // more than the pipe latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  line_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  line_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_VP_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending;
  int cyc = 0;
  bit flat_out = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  homogeneous_line_clip_viewport_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  hlcv_line_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Watchdog: any hang lands here.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("homogeneous_line_clip_viewport_unit_tb: errors");
      $finish;
    end
  end

  // Either side idles ~22% of the time, except in a quiet phase where both run flat out.
  function automatic bit take_gap();
    if (flat_out) return 1'b0;
    return $urandom_range(0, 99) < 22;
  endfunction

  // Receiver: random back-pressure plus one long hold so the pipe fills and in_ready drops.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && cyc > 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_gap();
    end
  end

  function automatic line_in_t mk_line(int ax, int ay, int az, int aw, logic [31:0] ac,
                                       int bx, int by, int bz, int bw, logic [31:0] bc);
    line_in_t l;
    l.a_x = ax; l.a_y = ay; l.a_z = az; l.a_w = aw; l.a_color = ac;
    l.b_x = bx; l.b_y = by; l.b_z = bz; l.b_w = bw; l.b_color = bc;
    return l;
  endfunction

  // Coordinate near the clip volume of w: within +-2|w| so clipping really happens.
  function automatic int near_coord(int w);
    longint span;
    span = (w < 0) ? -longint'(w) : longint'(w);
    return int'($signed({1'b0, $urandom_range(0, 32'(4 * span))}) - 2 * span);
  endfunction

  function automatic line_in_t rand_line();
    line_in_t l;
    int aw, bw;
    if ($urandom_range(0, 9) < 2) begin
      // raw noise over every bit
      l = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      aw = $urandom_range(Q / 16, 8 * Q);
      bw = $urandom_range(Q / 16, 8 * Q);
      if ($urandom_range(0, 15) == 0) aw = -aw;
      if ($urandom_range(0, 31) == 0) bw = 0;
      l = mk_line(near_coord(aw), near_coord(aw), near_coord(aw), aw, $urandom,
                  near_coord(bw), near_coord(bw), near_coord(bw), bw, $urandom);
    end
    return l;
  endfunction

  // Offer one line; valid stays up (no re-drive glitch) when there is no gap.
  task automatic send_line(line_in_t l);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_viewport(int w, int h, int dlo, int dhi);
    write_reg(REG_VP_WIDTH, w);
    write_reg(REG_VP_HEIGHT, h);
    write_reg(REG_DEPTH_MIN, dlo);
    write_reg(REG_DEPTH_MAX, dhi);
  endtask

  task automatic run_directed();
    int mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_line('0);                                                      // both w zero
    send_line(mk_line(0, 0, 0, Q, 32'h0, Q/2, Q/2, Q/2, Q, 32'hFFFF_FFFF)); // inside
    send_line(mk_line(2*Q, 0, 0, Q, 32'hFF00_FF00, 0, 0, 0, Q, 32'h00FF_00FF)); // x > w
    send_line(mk_line(-3*Q, 0, 0, Q, 32'h1234_5678, 0, 0, 0, Q, 32'h8765_4321)); // x < -w
    send_line(mk_line(0, 5*Q, 0, 2*Q, 32'hFFFF_FFFF, 0, -Q, 0, 2*Q, 32'h0)); // y > w
    send_line(mk_line(0, 0, -4*Q, Q, 32'h80808080, 0, 0, 3*Q, Q, 32'h7F7F7F7F)); // z both
    send_line(mk_line(3*Q, -3*Q, 2*Q, Q, 32'hAA55AA55, -3*Q, 3*Q, -2*Q, Q, 32'h55AA55AA));
    send_line(mk_line(2*Q, 0, 0, Q, 32'h0, 2*Q, 0, 0, Q, 32'hFF));  // zero denominator
    send_line(mk_line(2*Q, 0, 0, Q, 32'h0, 4*Q, 0, 0, Q, 32'hFF));  // negative denominator
    send_line(mk_line(2*Q, 0, 0, Q, 32'h0, 2*Q - 1, 0, 0, Q, 32'hFFFFFFFF)); // huge t
    send_line(mk_line(mx, mx, mx, mx, 32'hFFFF_FFFF, mx, mx, mx, mx, 32'hFFFF_FFFF));
    send_line(mk_line(mn, mn, mn, mn, 32'h0, mn, mn, mn, mn, 32'h0));
    send_line(mk_line(mx, mn, mx, mn, 32'hFF00_00FF, mn, mx, mn, mx, 32'h00FF_FF00));
    send_line(mk_line(0, 0, 0, Q, 32'h0, 0, 0, 0, 0, 32'hFFFF_FFFF)); // only B w zero
    send_line(mk_line(Q/2, Q/2, 0, -Q, 32'h0102_0304, -Q/2, 0, Q/4, -Q, 32'h0)); // w < 0
    send_line(mk_line(mx, 0, 0, 1, 32'h0, 0, 0, 0, Q, 32'hFFFF_FFFF)); // divide saturates
    send_line(mk_line(Q, Q, Q, Q, 32'h0, -Q, -Q, -Q, Q, 32'hFF)); // on the planes
  endtask

  task automatic run_random(int n);
    repeat (n) send_line(rand_line());
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values
    run_directed();
    run_random(300);
    drain();

    // smallest viewport, flat depth
    set_viewport(1, 1, 0, 0);
    run_directed();
    run_random(200);
    drain();

    // largest viewport, inverted full depth range; both sides run with no idling
    set_viewport(8192, 8192, 65536, 0);
    flat_out = 1'b1;
    run_random(250);
    drain();
    flat_out = 1'b0;

    // out-of-range values are used as written: zero width, all-ones fields
    set_viewport(0, 16383, 131071, 131071);
    run_random(120);
    drain();

    set_viewport($urandom_range(1, 8192), $urandom_range(1, 8192),
                 $urandom_range(0, 65536), $urandom_range(0, 65536));
    run_random(250);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("homogeneous_line_clip_viewport_unit_tb: clean");
    end else begin
      $display("homogeneous_line_clip_viewport_unit_tb: errors");
    end
    $finish;
  end

endmodule
